// File: src/obsw_pkg.sv
// ----------------------------------------------------------------------------
// obsw_pkg: shared types, codes and tables of the obstacle steering block
// sequencer step codes, command bundle, exponent root table and atan table
// ----------------------------------------------------------------------------
package obsw_pkg;

    localparam int NUM_REGS = 8;

    // sequencer steps, also the datapath operation of that cycle
    localparam logic [5:0] ST_IDLE    = 6'd0;
    localparam logic [5:0] ST_CL_SET  = 6'd1;
    localparam logic [5:0] ST_CL_DIV  = 6'd2;
    localparam logic [5:0] ST_CL_END  = 6'd3;
    localparam logic [5:0] ST_PW_SET  = 6'd4;
    localparam logic [5:0] ST_PW_SQM  = 6'd5;
    localparam logic [5:0] ST_PW_SQW  = 6'd6;
    localparam logic [5:0] ST_PW_LOG  = 6'd7;
    localparam logic [5:0] ST_PW_LOGW = 6'd8;
    localparam logic [5:0] ST_PW_EXM  = 6'd9;
    localparam logic [5:0] ST_PW_EXW  = 6'd10;
    localparam logic [5:0] ST_PW_END  = 6'd11;
    localparam logic [5:0] ST_FW_M    = 6'd12;
    localparam logic [5:0] ST_CR_M    = 6'd13;
    localparam logic [5:0] ST_CR_W    = 6'd14;
    localparam logic [5:0] ST_FC_M    = 6'd15;
    localparam logic [5:0] ST_MX_M    = 6'd16;
    localparam logic [5:0] ST_MY1_M   = 6'd17;
    localparam logic [5:0] ST_MY2_M   = 6'd18;
    localparam logic [5:0] ST_SQ1_M   = 6'd19;
    localparam logic [5:0] ST_SQ2_M   = 6'd20;
    localparam logic [5:0] ST_SQ_W    = 6'd21;
    localparam logic [5:0] ST_IT      = 6'd22;
    localparam logic [5:0] ST_IT_END  = 6'd23;
    localparam logic [5:0] ST_OM1_M   = 6'd24;
    localparam logic [5:0] ST_CF2_M   = 6'd25;
    localparam logic [5:0] ST_CF2_W   = 6'd26;
    localparam logic [5:0] ST_FA_M    = 6'd27;
    localparam logic [5:0] ST_FA_W    = 6'd28;
    localparam logic [5:0] ST_OM2_M   = 6'd29;
    localparam logic [5:0] ST_BI_M    = 6'd30;
    localparam logic [5:0] ST_BI_W    = 6'd31;
    localparam logic [5:0] ST_HA_M    = 6'd32;
    localparam logic [5:0] ST_HA_W    = 6'd33;
    localparam logic [5:0] ST_RL_M    = 6'd34;
    localparam logic [5:0] ST_RR_M    = 6'd35;
    localparam logic [5:0] ST_RR_W    = 6'd36;
    localparam logic [5:0] ST_PUB     = 6'd37;

    // sensor select
    localparam logic [1:0] SEL_FRONT = 2'd0;
    localparam logic [1:0] SEL_LEFT  = 2'd1;
    localparam logic [1:0] SEL_RIGHT = 2'd2;

    localparam logic [16:0] ONE16   = 17'd65536;
    localparam logic [15:0] K030    = 16'd19661;
    localparam logic [16:0] K040    = 17'd26214;
    localparam logic [16:0] PI_Q13  = 17'd25736;

    typedef struct packed {
        logic [5:0] op;
        logic [4:0] cnt;
        logic [1:0] sel;
        logic       load;
        logic       pub;
    } t_cmd;

    typedef logic [15:0][31:0] t_pw_tab;

    // successive square roots of one half, Q0.32
    function automatic t_pw_tab f_pw_tab();
        t_pw_tab     tab;
        logic [63:0] prev;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        tab  = '0;
        prev = 64'd1 << 31;
        for (int j = 0; j < 16; j++) begin
            v = prev << 32;
            r = '0;
            b = 64'd1 << 62;
            for (int k = 0; k < 32; k++) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            tab[j] = r[31:0];
            prev   = r;
        end
        return tab;
    endfunction

    localparam t_pw_tab PW_TAB = f_pw_tab();

    // cordic arctangent steps, Q3.13
    function automatic logic [12:0] f_atan(input logic [3:0] i);
        logic [12:0] a;
        case (i)
            4'd0:    a = 13'd6434;
            4'd1:    a = 13'd3798;
            4'd2:    a = 13'd2007;
            4'd3:    a = 13'd1019;
            4'd4:    a = 13'd511;
            4'd5:    a = 13'd256;
            4'd6:    a = 13'd128;
            4'd7:    a = 13'd64;
            4'd8:    a = 13'd32;
            4'd9:    a = 13'd16;
            4'd10:   a = 13'd8;
            4'd11:   a = 13'd4;
            4'd12:   a = 13'd2;
            4'd13:   a = 13'd1;
            default: a = 13'd0;
        endcase
        return a;
    endfunction

endpackage

// File: src/obsw_ctrl.sv
// ----------------------------------------------------------------------------
// obsw_ctrl: sequencer of the obstacle steering block
// steps the datapath through one reading and owns both handshakes
// ----------------------------------------------------------------------------
module obsw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output obsw_pkg::t_cmd o_cmd
);
    import obsw_pkg::*;

    logic [5:0] r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [1:0] r_sel, n_sel;
    logic       r_ovalid, n_ovalid;
    logic       pub;

    assign pub = (r_state == ST_PUB) && (!r_ovalid || i_out_ready);

    always_comb begin
        n_state = r_state;
        n_cnt   = '0;
        n_sel   = r_sel;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CL_SET;
                    n_sel   = SEL_FRONT;
                end
            end
            ST_CL_SET:  n_state = ST_CL_DIV;
            ST_CL_DIV: begin
                if (r_cnt == 5'd15) n_state = ST_CL_END;
                else n_cnt = r_cnt + 5'd1;
            end
            ST_CL_END: begin
                if (r_sel == SEL_RIGHT) begin
                    n_state = ST_PW_SET;
                end else begin
                    n_state = ST_CL_SET;
                    n_sel   = r_sel + 2'd1;
                end
            end
            ST_PW_SET:  n_state = ST_PW_SQM;
            ST_PW_SQM: begin
                n_state = ST_PW_SQW;
                n_cnt   = r_cnt;
            end
            ST_PW_SQW: begin
                if (r_cnt == 5'd15) begin
                    n_state = ST_PW_LOG;
                end else begin
                    n_state = ST_PW_SQM;
                    n_cnt   = r_cnt + 5'd1;
                end
            end
            ST_PW_LOG:  n_state = ST_PW_LOGW;
            ST_PW_LOGW: n_state = ST_PW_EXM;
            ST_PW_EXM: begin
                n_state = ST_PW_EXW;
                n_cnt   = r_cnt;
            end
            ST_PW_EXW: begin
                if (r_cnt == 5'd15) begin
                    n_state = ST_PW_END;
                end else begin
                    n_state = ST_PW_EXM;
                    n_cnt   = r_cnt + 5'd1;
                end
            end
            ST_PW_END:  n_state = ST_FW_M;
            ST_FW_M:    n_state = ST_CR_M;
            ST_CR_M:    n_state = ST_CR_W;
            ST_CR_W:    n_state = ST_FC_M;
            ST_FC_M:    n_state = ST_MX_M;
            ST_MX_M:    n_state = ST_MY1_M;
            ST_MY1_M:   n_state = ST_MY2_M;
            ST_MY2_M:   n_state = ST_SQ1_M;
            ST_SQ1_M:   n_state = ST_SQ2_M;
            ST_SQ2_M:   n_state = ST_SQ_W;
            ST_SQ_W:    n_state = ST_IT;
            ST_IT: begin
                if (r_cnt == 5'd20) n_state = ST_IT_END;
                else n_cnt = r_cnt + 5'd1;
            end
            ST_IT_END:  n_state = ST_OM1_M;
            ST_OM1_M:   n_state = ST_CF2_M;
            ST_CF2_M:   n_state = ST_CF2_W;
            ST_CF2_W:   n_state = ST_FA_M;
            ST_FA_M:    n_state = ST_FA_W;
            ST_FA_W:    n_state = ST_OM2_M;
            ST_OM2_M:   n_state = ST_BI_M;
            ST_BI_M:    n_state = ST_BI_W;
            ST_BI_W:    n_state = ST_HA_M;
            ST_HA_M:    n_state = ST_HA_W;
            ST_HA_W:    n_state = ST_RL_M;
            ST_RL_M:    n_state = ST_RR_M;
            ST_RR_M:    n_state = ST_RR_W;
            ST_RR_W:    n_state = ST_PUB;
            ST_PUB: begin
                if (pub) n_state = ST_IDLE;
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (pub) n_ovalid = 1'b1;
        else if (r_ovalid && i_out_ready) n_ovalid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_sel    <= SEL_FRONT;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_sel    <= n_sel;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;

    assign o_cmd.op   = r_state;
    assign o_cmd.cnt  = r_cnt;
    assign o_cmd.sel  = r_sel;
    assign o_cmd.load = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.pub  = pub;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 5'd20)
        else $error("iteration counter out of range");

    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel != 2'd3)
        else $error("sensor select out of range");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid) |=> (r_state == ST_CL_SET && r_sel == SEL_FRONT))
        else $error("accepted request did not start the sequence");

    a_pub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pub |=> (r_ovalid && r_state == ST_IDLE))
        else $error("finished result not presented");

endmodule

// File: src/obsw_dp.sv
// ----------------------------------------------------------------------------
// obsw_dp: datapath of the obstacle steering block
// settings, shared multiplier, divider, sqrt and cordic, wheel state
// ----------------------------------------------------------------------------
module obsw_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic [2:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_wdata,
    input  obsw_pkg::t_cmd i_cmd,
    input  logic [47:0]    i_in_data,
    output logic [31:0]    o_out_data
);
    import obsw_pkg::*;

    localparam logic [1:0] KIND_ZERO = 2'd0;
    localparam logic [1:0] KIND_ONE  = 2'd1;
    localparam logic [1:0] KIND_DIV  = 2'd2;

    localparam logic [1:0] SP_NONE = 2'd0;
    localparam logic [1:0] SP_ONE  = 2'd1;
    localparam logic [1:0] SP_ZERO = 2'd2;

    function automatic logic signed [15:0] f_cmd(input logic signed [25:0] v,
                                                 input logic [19:0] ms);
        logic signed [25:0] lim;
        logic signed [25:0] c;
        logic signed [21:0] s;
        lim = $signed({6'b0, ms});
        c   = v;
        if (c < -lim) c = -lim;
        else if (c > lim) c = lim;
        s = c[25:4];
        if (s < -22'sd32768) return -16'sd32768;
        if (s > 22'sd32767) return 16'sd32767;
        return s[15:0];
    endfunction

    function automatic logic signed [15:0] f_ramp(input logic signed [15:0] cur,
                                                  input logic signed [16:0] step);
        logic signed [17:0] s;
        s = {{2{cur[15]}}, cur} + {step[16], step};
        if (s < -18'sd32768) return -16'sd32768;
        if (s > 18'sd32767) return 16'sd32767;
        return s[15:0];
    endfunction

    // settings
    logic [31:0] r_cfg [NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) r_cfg[i] <= '0;
        end else if (i_cfg_wr_en) begin
            r_cfg[i_cfg_index] <= i_cfg_wdata;
        end
    end

    logic [15:0] f_rng, f_crit, s_rng, s_crit, base, smin, smax, wmax;
    logic [15:0] expo, wbase, gfront, gside, ghead, gcurv, gbias, alpha;
    logic [19:0] max_s;

    assign f_rng  = r_cfg[0][31:16];
    assign f_crit = r_cfg[0][15:0];
    assign s_rng  = r_cfg[1][31:16];
    assign s_crit = r_cfg[1][15:0];
    assign base   = r_cfg[2][31:16];
    assign smin   = r_cfg[2][15:0];
    assign smax   = r_cfg[3][31:16];
    assign wmax   = r_cfg[3][15:0];
    assign expo   = r_cfg[4][31:16];
    assign wbase  = r_cfg[4][15:0];
    assign gfront = r_cfg[5][31:16];
    assign gside  = r_cfg[5][15:0];
    assign ghead  = r_cfg[6][31:16];
    assign gcurv  = r_cfg[6][15:0];
    assign gbias  = r_cfg[7][31:16];
    assign alpha  = r_cfg[7][15:0];
    assign max_s  = {smax, 4'b0};

    // working registers
    logic [15:0] r_df, r_dl, r_dr;
    logic [16:0] r_cf, r_cl, r_cr;
    logic [1:0]  r_kind;
    logic [15:0] r_rem, r_den, r_quo;
    logic [31:0] r_pm;
    logic [15:0] r_frac;
    logic [3:0]  r_pp;
    logic [1:0]  r_pspec;
    logic [24:0] r_ymag;
    logic [32:0] r_pres;
    logic [16:0] r_pw;
    logic [15:0] r_fwd;
    logic [16:0] r_corr;
    logic signed [21:0] r_mx;
    logic signed [17:0] r_my;
    logic [41:0] r_sqa, r_sqv;
    logic [21:0] r_sqrem;
    logic [20:0] r_sqroot;
    logic signed [31:0] r_cx, r_cy;
    logic signed [16:0] r_cz;
    logic        r_cspec, r_cneg;
    logic signed [16:0] r_theta;
    logic [20:0] r_vmag;
    logic [16:0] r_ct;
    logic [16:0] r_factor;
    logic signed [25:0] r_omega;
    logic signed [15:0] r_cmd_l, r_cmd_r;
    logic signed [15:0] r_left, r_right;
    logic signed [15:0] r_out_l, r_out_r;
    logic signed [67:0] r_prod;

    // shared multiplier
    logic signed [33:0] mul_a, mul_b;
    logic [16:0] avg;
    logic [20:0] lmag;
    logic signed [17:0] cdiff;

    assign avg   = 17'(({1'b0, r_cl} + {1'b0, r_cr}) >> 1);
    assign lmag  = {1'b0, (4'd0 - r_pp) == 4'd0 ? 5'd16 : {1'b0, 4'd0 - r_pp}, 15'b0} << 1;
    assign cdiff = $signed({1'b0, r_cr}) - $signed({1'b0, r_cl});

    logic [20:0] lmag_f;
    assign lmag_f = lmag - {5'b0, r_frac};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            ST_PW_SQM: begin mul_a = {2'b0, r_pm};  mul_b = {2'b0, r_pm}; end
            ST_PW_LOG: begin mul_a = {13'b0, lmag_f}; mul_b = {18'b0, expo}; end
            ST_PW_EXM: begin
                mul_a = {1'b0, r_pres};
                mul_b = {2'b0, PW_TAB[i_cmd.cnt[3:0]]};
            end
            ST_FW_M:  begin mul_a = {18'b0, base};   mul_b = {17'b0, r_pw}; end
            ST_CR_M:  begin mul_a = {18'b0, K030};   mul_b = {17'b0, avg}; end
            ST_FC_M:  begin mul_a = {18'b0, r_fwd};  mul_b = {17'b0, r_corr}; end
            ST_MX_M:  begin mul_a = {18'b0, gfront}; mul_b = {17'b0, r_cf}; end
            ST_MY1_M: begin mul_a = {18'b0, gside};  mul_b = {17'b0, r_cl}; end
            ST_MY2_M: begin mul_a = {18'b0, gside};  mul_b = {17'b0, r_cr}; end
            ST_SQ1_M: begin
                mul_a = {{12{r_mx[21]}}, r_mx};
                mul_b = {{12{r_mx[21]}}, r_mx};
            end
            ST_SQ2_M: begin
                mul_a = {{16{r_my[17]}}, r_my};
                mul_b = {{16{r_my[17]}}, r_my};
            end
            ST_OM1_M: begin mul_a = {18'b0, ghead}; mul_b = {{17{r_theta[16]}}, r_theta}; end
            ST_CF2_M: begin mul_a = {17'b0, r_cf};  mul_b = {17'b0, r_cf}; end
            ST_FA_M:  begin mul_a = {18'b0, gcurv}; mul_b = {17'b0, r_ct}; end
            ST_OM2_M: begin mul_a = {{8{r_omega[25]}}, r_omega}; mul_b = {17'b0, r_factor}; end
            ST_BI_M:  begin mul_a = {18'b0, gbias}; mul_b = {{16{cdiff[17]}}, cdiff}; end
            ST_HA_M:  begin mul_a = {{8{r_omega[25]}}, r_omega}; mul_b = {18'b0, wbase}; end
            ST_RL_M: begin
                mul_a = {18'b0, alpha};
                mul_b = 34'($signed({r_cmd_l[15], r_cmd_l}) - $signed({r_left[15], r_left}));
                mul_b = {{17{mul_b[16]}}, mul_b[16:0]};
            end
            ST_RR_M: begin
                mul_a = {18'b0, alpha};
                mul_b = 34'($signed({r_cmd_r[15], r_cmd_r}) - $signed({r_right[15], r_right}));
                mul_b = {{17{mul_b[16]}}, mul_b[16:0]};
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // closeness front end
    logic [15:0] cl_d, cl_rng, cl_crit;
    logic [16:0] div_sh;
    logic [16:0] cl_val;

    always_comb begin
        case (i_cmd.sel)
            SEL_FRONT: begin cl_d = r_df; cl_rng = f_rng; cl_crit = f_crit; end
            SEL_LEFT:  begin cl_d = r_dl; cl_rng = s_rng; cl_crit = s_crit; end
            default:   begin cl_d = r_dr; cl_rng = s_rng; cl_crit = s_crit; end
        endcase
    end

    assign div_sh = {r_rem, 1'b0};

    always_comb begin
        case (r_kind)
            KIND_ONE: cl_val = ONE16;
            KIND_DIV: cl_val = {1'b0, r_quo};
            default:  cl_val = '0;
        endcase
    end

    // power front end
    logic [15:0] px;
    logic [3:0]  pmsb;
    logic [32:0] psq;
    logic [8:0]  pn;
    logic [32:0] psh;

    assign px = 16'(ONE16 - r_cf);
    always_comb begin
        pmsb = '0;
        for (int j = 0; j < 16; j++)
            if (px[j]) pmsb = 4'(j);
    end
    assign psq = r_prod[63:31];
    assign pn  = r_ymag[24:16];
    assign psh = r_pres >> pn[5:0];

    // sqrt and cordic steps
    logic [23:0] sq_sh, sq_trial;
    logic [3:0]  ci;
    logic signed [31:0] cx_s, cy_s;
    logic signed [31:0] mx32, my32;

    assign sq_sh    = {r_sqrem, r_sqv[41:40]};
    assign sq_trial = {1'b0, r_sqroot, 2'b01};
    assign ci       = i_cmd.cnt[3:0];
    assign cx_s     = r_cx >>> ci;
    assign cy_s     = r_cy >>> ci;
    assign mx32     = {{10{r_mx[21]}}, r_mx};
    assign my32     = {{14{r_my[17]}}, r_my};

    // turn rate and wheel commands
    logic signed [25:0] om_sum, om_lim;
    logic signed [23:0] half;
    logic signed [25:0] half26, vm26;

    assign om_sum = r_omega + $signed(r_prod[41:16]);
    assign om_lim = $signed({10'b0, wmax});
    assign half   = $signed(r_prod[32:9]);
    assign half26 = {{2{half[23]}}, half};
    assign vm26   = $signed({5'b0, r_vmag});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_df <= i_in_data[15:0];
            r_dl <= i_in_data[31:16];
            r_dr <= i_in_data[47:32];
        end
        case (i_cmd.op)
            ST_CL_SET: begin
                if (cl_d == 16'd0 || cl_d >= cl_rng) r_kind <= KIND_ZERO;
                else if (cl_d <= cl_crit) r_kind <= KIND_ONE;
                else r_kind <= KIND_DIV;
                r_rem <= cl_rng - cl_d;
                r_den <= cl_rng - cl_crit;
                r_quo <= '0;
            end
            ST_CL_DIV: begin
                if (div_sh >= {1'b0, r_den}) begin
                    r_rem <= 16'(div_sh - {1'b0, r_den});
                    r_quo <= {r_quo[14:0], 1'b1};
                end else begin
                    r_rem <= div_sh[15:0];
                    r_quo <= {r_quo[14:0], 1'b0};
                end
            end
            ST_CL_END: begin
                case (i_cmd.sel)
                    SEL_FRONT: r_cf <= cl_val;
                    SEL_LEFT:  r_cl <= cl_val;
                    default:   r_cr <= cl_val;
                endcase
            end
            ST_PW_SET: begin
                r_pp   <= pmsb;
                r_pm   <= {16'b0, px} << (5'd31 - {1'b0, pmsb});
                r_frac <= '0;
                if (expo == 16'd0 || r_cf == 17'd0) r_pspec <= SP_ONE;
                else if (r_cf == ONE16) r_pspec <= SP_ZERO;
                else r_pspec <= SP_NONE;
            end
            ST_PW_SQW: begin
                if (psq[32]) begin
                    r_pm <= psq[32:1];
                    r_frac[4'd15 - ci] <= 1'b1;
                end else begin
                    r_pm <= psq[31:0];
                end
            end
            ST_PW_LOGW: begin
                r_ymag <= r_prod[36:12];
                r_pres <= 33'h1_0000_0000;
            end
            ST_PW_EXW: begin
                if (r_ymag[4'd15 - ci]) r_pres <= {1'b0, r_prod[63:32]};
            end
            ST_PW_END: begin
                if (r_pspec == SP_ONE) r_pw <= ONE16;
                else if (r_pspec == SP_ZERO || pn >= 9'd33) r_pw <= '0;
                else r_pw <= psh[32:16];
            end
            ST_CR_M: begin
                if (r_prod[31:16] < smin) r_fwd <= smin;
                else if (r_prod[31:16] > smax) r_fwd <= smax;
                else r_fwd <= r_prod[31:16];
            end
            ST_CR_W: begin
                if ((ONE16 - {1'b0, r_prod[31:16]}) < K040) r_corr <= K040;
                else r_corr <= ONE16 - {1'b0, r_prod[31:16]};
            end
            ST_MX_M:  r_fwd <= r_prod[31:16];
            ST_MY1_M: r_mx <= $signed({2'b0, r_fwd, 4'b0}) - $signed({6'b0, r_prod[31:16]});
            ST_MY2_M: r_my <= $signed({2'b0, r_prod[31:16]});
            ST_SQ1_M: r_my <= r_my - $signed({2'b0, r_prod[31:16]});
            ST_SQ2_M: r_sqa <= r_prod[41:0];
            ST_SQ_W: begin
                r_sqv    <= r_sqa + r_prod[41:0];
                r_sqrem  <= '0;
                r_sqroot <= '0;
                r_cspec  <= (r_my == 18'sd0);
                r_cneg   <= r_mx[21];
                if (r_mx[21]) begin
                    r_cz <= (r_my > 18'sd0) ? $signed(PI_Q13) : -$signed(PI_Q13);
                    r_cx <= (-mx32) <<< 8;
                    r_cy <= (-my32) <<< 8;
                end else begin
                    r_cz <= '0;
                    r_cx <= mx32 <<< 8;
                    r_cy <= my32 <<< 8;
                end
            end
            ST_IT: begin
                r_sqv <= r_sqv << 2;
                if (sq_sh >= sq_trial) begin
                    r_sqrem  <= 22'(sq_sh - sq_trial);
                    r_sqroot <= {r_sqroot[19:0], 1'b1};
                end else begin
                    r_sqrem  <= sq_sh[21:0];
                    r_sqroot <= {r_sqroot[19:0], 1'b0};
                end
                if (i_cmd.cnt < 5'd14) begin
                    if (r_cy > 32'sd0) begin
                        r_cx <= r_cx + cy_s;
                        r_cy <= r_cy - cx_s;
                        r_cz <= r_cz + $signed({4'b0, f_atan(ci)});
                    end else begin
                        r_cx <= r_cx - cy_s;
                        r_cy <= r_cy + cx_s;
                        r_cz <= r_cz - $signed({4'b0, f_atan(ci)});
                    end
                end
            end
            ST_IT_END: begin
                if (r_cspec) r_theta <= r_cneg ? $signed(PI_Q13) : 17'sd0;
                else r_theta <= r_cz;
                r_vmag <= ({1'b0, max_s} < r_sqroot) ? {1'b0, max_s} : r_sqroot;
            end
            ST_CF2_M: r_omega <= $signed(r_prod[38:13]);
            ST_CF2_W: r_ct <= r_prod[32:16];
            ST_FA_W:  r_factor <= 17'd4096 + {1'b0, r_prod[31:16]};
            ST_BI_M:  r_omega <= $signed(r_prod[37:12]);
            ST_BI_W: begin
                if (om_sum < -om_lim) r_omega <= -om_lim;
                else if (om_sum > om_lim) r_omega <= om_lim;
                else r_omega <= om_sum;
            end
            ST_HA_W: begin
                r_cmd_l <= f_cmd(vm26 - half26, max_s);
                r_cmd_r <= f_cmd(vm26 + half26, max_s);
            end
            default: begin
            end
        endcase
        if (i_cmd.pub) begin
            r_out_l <= r_left;
            r_out_r <= r_right;
        end
    end

    // wheel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_right <= '0;
        end else if (i_cmd.op == ST_RR_M) begin
            r_left <= f_ramp(r_left, $signed(r_prod[32:16]));
        end else if (i_cmd.op == ST_RR_W) begin
            r_right <= f_ramp(r_right, $signed(r_prod[32:16]));
        end
    end

    assign o_out_data = {r_out_r, r_out_l};

endmodule

// File: src/obstacle_steering_wheel_speeds.sv
// ----------------------------------------------------------------------------
// obstacle_steering_wheel_speeds: range readings to ramped wheel speeds
// closeness, speed shaping, repulsion, heading and wheel ramp per reading
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one request: front, left and right distance in cm
//   m_axis returns one result per request: ramped left and right wheel
//   speeds, signed q8.8, after the update of the stored speeds
//   settings are written on the plain write port while the block is idle;
//   eight 32 bit registers, index 0 to 7, two 16 bit settings each
// timing
//   a request is taken only when the sequencer is idle; the result becomes
//   valid in the same cycle that the sequencer is idle again, so a new
//   request is taken only once the last one has been published
//   the run time is set by the shared datapath: three 16 step divisions,
//   a squaring loop for the exponent log and a multiply loop for its power, a 21
//   step square root that also runs the 14 step cordic, and single multiplies
// reset
//   synchronous active low: settings and stored wheel speeds go to zero
// stall
//   the result sits in an output register; the next request is taken and
//   worked on meanwhile, and only its own publish waits for the slot
// ----------------------------------------------------------------------------
module obstacle_steering_wheel_speeds (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    // readings
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // dist_front, dist_left, dist_right
    // wheel speeds
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // left_wheel_speed, right_wheel_speed
);
    import obsw_pkg::*;

    t_cmd cmd;

    // sequencer: request handshake, step and iteration counting
    obsw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    // arithmetic: settings, shared multiplier and iterative units
    obsw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .i_in_data   (s_axis_tdata),
        .o_out_data  (m_axis_tdata)
    );

endmodule
